// File: hw/rtl/mnp_pkg.sv
// Shared constants for the Montgomery n' inverse chain.
package mnp_pkg;

  localparam int DEFAULT_WORD_WIDTH = 32;
  localparam int FIELD_W            = 32;
  localparam int CFG_W              = 6;
  localparam logic [CFG_W-1:0] WORD_BITS_RESET = 6'd32;

endpackage

// File: hw/rtl/mnp_cell.sv
// One lifting cell: decides bit K of the inverse and updates the running product.
module mnp_cell #(
  parameter int WW = mnp_pkg::DEFAULT_WORD_WIDTH,
  parameter int K  = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [mnp_pkg::CFG_W-1:0]   word_bits,
  input  logic                        in_valid,
  input  logic [mnp_pkg::FIELD_W-1:0] in_x,
  input  logic [WW-1:0]               in_r,
  input  logic [WW-1:0]               in_p,
  output logic                        out_valid,
  output logic [mnp_pkg::FIELD_W-1:0] out_x,
  output logic [WW-1:0]               out_r,
  output logic [WW-1:0]               out_p
);

  localparam logic [mnp_pkg::CFG_W-1:0] KB = mnp_pkg::CFG_W'(K);

  logic [WW+mnp_pkg::FIELD_W-1:0] x_ext;
  logic [WW-1:0]                  x_w;
  logic                           hit;
  logic [WW-1:0]                  r_next;
  logic [WW-1:0]                  p_next;

  assign x_ext = {{WW{1'b0}}, in_x};
  assign x_w   = x_ext[WW-1:0];

  // (x*r) mod 2^(K+1) > 2^K  <=>  bit K set and some lower bit set
  assign hit = (KB < word_bits) && in_p[K] && (|in_p[K-1:0]);

  always_comb begin
    r_next    = in_r;
    r_next[K] = in_r[K] | hit;
    p_next    = hit ? (in_p + (x_w << K)) : in_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= in_x;
      out_r <= r_next;
      out_p <= p_next;
    end
  end

endmodule

// File: hw/rtl/montgomery_n_prime.sv
// Inverse of a modulus word modulo 2^word_bits by a chain of lifting cells, and
// n' = -inverse mod 2^WORD_WIDTH. One modulus word is taken every cycle while
// the output side does not stall. The path holds one input register, loaded on
// the accepting edge, and WORD_WIDTH-1 cells, one per lifted bit. A result
// passes the input register and then each cell register in order before it is
// offered. A stall on the output side holds the whole chain. The user must
// change word_bits only while idle; the block itself does not enforce it.
module montgomery_n_prime #(
  parameter int WORD_WIDTH = mnp_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mnp_pkg::CFG_W-1:0]   cfg_data,      // word_bits
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mnp_pkg::FIELD_W-1:0] s_axis_tdata,  // modulus_word
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [2*mnp_pkg::FIELD_W-1:0] m_axis_tdata // inverse_word, n_prime_word
);

  localparam int NC = WORD_WIDTH - 1;

  logic [mnp_pkg::CFG_W-1:0]   word_bits;
  logic                        adv;
  logic                        v   [0:NC];
  logic [mnp_pkg::FIELD_W-1:0] x   [0:NC];
  logic [WORD_WIDTH-1:0]       r   [0:NC];
  logic [WORD_WIDTH-1:0]       p   [0:NC];
  logic [WORD_WIDTH+mnp_pkg::FIELD_W-1:0] x_ext;
  logic [WORD_WIDTH+mnp_pkg::FIELD_W-1:0] inv_ext;
  logic [WORD_WIDTH+mnp_pkg::FIELD_W-1:0] np_ext;
  logic [WORD_WIDTH-1:0]       neg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits <= mnp_pkg::WORD_BITS_RESET;
    end else if (cfg_valid) begin
      word_bits <= cfg_data;
    end
  end

  assign adv           = !v[NC] || m_axis_tready;
  assign s_axis_tready = adv;

  // input register: r = 1, so the running product starts as x
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0] <= s_axis_tdata;
    end
  end

  assign x_ext = {{WORD_WIDTH{1'b0}}, x[0]};
  assign p[0]  = x_ext[WORD_WIDTH-1:0];
  assign r[0]  = WORD_WIDTH'(1);

  for (genvar k = 1; k <= NC; k++) begin : g_cell
    mnp_cell #(
      .WW (WORD_WIDTH),
      .K  (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .word_bits (word_bits),
      .in_valid  (v[k-1]),
      .in_x      (x[k-1]),
      .in_r      (r[k-1]),
      .in_p      (p[k-1]),
      .out_valid (v[k]),
      .out_x     (x[k]),
      .out_r     (r[k]),
      .out_p     (p[k])
    );
  end

  assign neg_r   = {WORD_WIDTH{1'b0}} - r[NC];
  assign inv_ext = {{mnp_pkg::FIELD_W{1'b0}}, r[NC]};
  assign np_ext  = {{mnp_pkg::FIELD_W{1'b0}}, neg_r};

  assign m_axis_tvalid = v[NC];
  assign m_axis_tdata  = {np_ext[mnp_pkg::FIELD_W-1:0], inv_ext[mnp_pkg::FIELD_W-1:0]};

endmodule
